/* src/mlfq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mlfq_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_ADMIT    = 2'd0,
    OP_WAKE     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_REPORT   = 2'd3
  } op_t;

  // outcome of the task in flight
  typedef enum logic [1:0] {
    OC_FINISHED = 2'd0,
    OC_FULL     = 2'd1,
    OC_PREEMPT  = 2'd2,
    OC_BLOCKED  = 2'd3
  } outc_t;

  // status codes of a result
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_BUSY    = 2'd3;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned QUANT_W = 24;
  localparam logic [QUANT_W-1:0] QUANT_RST = 24'd1000000;

  typedef struct packed {
    op_t               op;
    logic              proc_class;
    outc_t             outcome;
    logic [TIME_W-1:0] current_time;
    logic [TIME_W-1:0] blocked_until;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot;
    logic [1:0]         level;
    logic [QUANT_W-1:0] quantum;
    logic [4:0]         woken_count;
  } res_t;

endpackage

`default_nettype wire

/* src/mlfq_process_scheduler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Admit tests one slot per cycle, a refused dispatch skips the dispatch step, and wake
// handles each blocked-ring entry by ring read, slot store read, compare and requeue
// throughput: one item at a time in the back engine; a two-entry input queue and a
// result register let both sides stall independently
// reset: synchronous active low; all slots free, all queues empty, no task in flight,
// base quantum 1000000; slot stores are not cleared

module mlfq_process_scheduler_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        in_full,
  input  wire  [1:0]  in_op,
  input  wire         in_proc_class,
  input  wire  [1:0]  in_outcome,
  input  wire  [47:0] in_current_time,
  input  wire  [47:0] in_blocked_until,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [1:0]  out_level,
  output logic [23:0] out_quantum,
  output logic [4:0]  out_woken_count,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [23:0] cfg_base_quantum
);

  logic                          fr_valid;
  mlfq_pkg::item_t               fr_item;
  logic                          fr_take;
  logic                          res_valid;
  mlfq_pkg::res_t                res;
  logic                          res_ready;
  mlfq_pkg::res_t                out_r;
  logic                          out_valid_r;
  logic [mlfq_pkg::QUANT_W-1:0]  bq_r;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bq_r <= mlfq_pkg::QUANT_RST;
    end else if (cfg_valid) begin
      bq_r <= cfg_base_quantum;
    end
  end

  mlfq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .op           (in_op),
    .proc_class   (in_proc_class),
    .outcome      (in_outcome),
    .current_time (in_current_time),
    .blocked_until(in_blocked_until),
    .fr_valid     (fr_valid),
    .fr_item      (fr_item),
    .fr_take      (fr_take)
  );

  mlfq_back #(.SLOTS(SLOTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .base_quantum(bq_r),
    .fr_valid    (fr_valid),
    .fr_item     (fr_item),
    .fr_take     (fr_take),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  // result register
  assign res_ready = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_status      = out_r.status;
  assign out_slot        = out_r.slot;
  assign out_level       = out_r.level;
  assign out_quantum     = out_r.quantum;
  assign out_woken_count = out_r.woken_count;

endmodule

`default_nettype wire

/* src/mlfq_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlfq_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  output logic                      full,
  input  wire  [1:0]                op,
  input  wire                       proc_class,
  input  wire  [1:0]                outcome,
  input  wire  [mlfq_pkg::TIME_W-1:0] current_time,
  input  wire  [mlfq_pkg::TIME_W-1:0] blocked_until,
  output logic                      fr_valid,
  output mlfq_pkg::item_t           fr_item,
  input  wire                       fr_take
);

  mlfq_pkg::item_t buf_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic            do_push;
  logic            do_pop;
  mlfq_pkg::item_t in_item;

  // classify the incoming item into typed fields
  always_comb begin
    in_item.op            = mlfq_pkg::op_t'(op);
    in_item.proc_class    = proc_class;
    in_item.outcome       = mlfq_pkg::outc_t'(outcome);
    in_item.current_time  = current_time;
    in_item.blocked_until = blocked_until;
  end

  assign full     = (cnt_r == 2'd2);
  assign fr_valid = (cnt_r != 2'd0);
  assign fr_item  = buf_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = fr_take && fr_valid;

  // two-entry item queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

/* src/mlfq_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlfq_back #(
  parameter int unsigned SLOTS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [mlfq_pkg::QUANT_W-1:0] base_quantum,
  input  wire                          fr_valid,
  input  mlfq_pkg::item_t              fr_item,
  output logic                         fr_take,
  output logic                         res_valid,
  output mlfq_pkg::res_t               res,
  input  wire                          res_ready
);

  localparam int unsigned PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WK_POP, S_WK_RD, S_WK_CMP, S_DSP, S_RES
  } state_t;

  state_t  state_r;
  mlfq_pkg::item_t it_r;

  // ready queues, blocked ring, per-slot stores
  logic [PW-1:0]         rq_mem [0:(4<<PW)-1];
  logic [PW-1:0]         bq_mem [0:SLOTS-1];
  logic [mlfq_pkg::TIME_W-1:0] wt_mem [0:SLOTS-1];
  logic                  cls_mem [0:SLOTS-1];

  logic [PW-1:0]  rq_head_r [4];
  logic [PW-1:0]  rq_tail_r [4];
  logic [CW-1:0]  rq_cnt_r  [4];
  logic [PW-1:0]  bq_head_r;
  logic [PW-1:0]  bq_tail_r;
  logic [CW-1:0]  bq_cnt_r;
  logic [SLOTS-1:0] busy_r;

  logic           fl_valid_r;
  logic [1:0]     fl_level_r;
  logic [PW-1:0]  fl_slot_r;

  logic [PW-1:0]  scan_r;
  logic [CW-1:0]  left_r;
  logic [CW-1:0]  wk_r;
  logic [PW-1:0]  s_r;
  logic [1:0]     lvl_r;

  logic [1:0]     st_r;
  logic [PW-1:0]  slot_r;
  logic [1:0]     level_r;
  logic [mlfq_pkg::QUANT_W-1:0] quant_r;

  logic [PW-1:0]  rq_rd_r;
  logic [PW-1:0]  bq_rd_r;
  logic [mlfq_pkg::TIME_W-1:0] wt_rd_r;
  logic           cls_rd_r;

  // push/pop requests
  logic           rq_push;
  logic [1:0]     rq_push_lv;
  logic [PW-1:0]  rq_push_slot;
  logic           rq_pop;
  logic           bq_push;
  logic [PW-1:0]  bq_push_slot;
  logic           bq_pop;
  logic           wt_we;
  logic           cls_we;
  logic [1:0]     pick_lv;
  logic           pick_ok;
  logic           start;
  logic           rep_go;
  logic           wake_hit;
  logic [PW+3:0]  slot_ext;
  logic [CW+4:0]  wk_ext;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    inc = (p == LAST) ? '0 : p + PW'(1);
  endfunction

  assign fr_take   = (state_r == S_IDLE);
  assign start     = fr_take && fr_valid;
  assign rep_go    = start && (fr_item.op == mlfq_pkg::OP_REPORT) && fl_valid_r;
  assign wake_hit  = (wt_rd_r < it_r.current_time);
  assign res_valid = (state_r == S_RES);

  // highest non-empty level
  always_comb begin
    pick_ok = 1'b1;
    priority if (rq_cnt_r[0] != '0) pick_lv = 2'd0;
    else if (rq_cnt_r[1] != '0)     pick_lv = 2'd1;
    else if (rq_cnt_r[2] != '0)     pick_lv = 2'd2;
    else if (rq_cnt_r[3] != '0)     pick_lv = 2'd3;
    else begin
      pick_lv = 2'd0;
      pick_ok = 1'b0;
    end
  end

  // queue operations requested by the current step
  always_comb begin
    rq_push      = 1'b0;
    rq_push_lv   = 2'd0;
    rq_push_slot = fl_slot_r;
    bq_push      = 1'b0;
    bq_push_slot = fl_slot_r;
    wt_we        = 1'b0;
    cls_we       = 1'b0;
    rq_pop       = (state_r == S_DSP);
    bq_pop       = (state_r == S_WK_POP);
    if (rep_go) begin
      unique case (fr_item.outcome)
        mlfq_pkg::OC_FINISHED: ;
        mlfq_pkg::OC_FULL: begin
          rq_push    = 1'b1;
          rq_push_lv = (fl_level_r == 2'd0) ? 2'd0 :
                       (fl_level_r == 2'd1) ? 2'd2 : 2'd3;
        end
        mlfq_pkg::OC_PREEMPT: begin
          rq_push    = 1'b1;
          rq_push_lv = fl_level_r;
        end
        mlfq_pkg::OC_BLOCKED: begin
          bq_push = 1'b1;
          wt_we   = 1'b1;
        end
        default: ;
      endcase
    end else if (state_r == S_SCAN && !busy_r[scan_r]) begin
      rq_push      = 1'b1;
      rq_push_lv   = {1'b0, it_r.proc_class};
      rq_push_slot = scan_r;
      cls_we       = 1'b1;
    end else if (state_r == S_WK_CMP) begin
      rq_push      = wake_hit;
      rq_push_lv   = {1'b0, cls_rd_r};
      rq_push_slot = s_r;
      bq_push      = !wake_hit;
      bq_push_slot = s_r;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (rq_push) rq_mem[{rq_push_lv, rq_tail_r[rq_push_lv]}] <= rq_push_slot;
    rq_rd_r <= rq_mem[{pick_lv, rq_head_r[pick_lv]}];
  end

  always_ff @(posedge clk) begin
    if (bq_push) bq_mem[bq_tail_r] <= bq_push_slot;
    bq_rd_r <= bq_mem[bq_head_r];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[fl_slot_r] <= fr_item.blocked_until;
    wt_rd_r <= wt_mem[bq_rd_r];
  end

  always_ff @(posedge clk) begin
    if (cls_we) cls_mem[scan_r] <= it_r.proc_class;
    cls_rd_r <= cls_mem[bq_rd_r];
  end

  // queue pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        rq_head_r[i] <= '0;
        rq_tail_r[i] <= '0;
        rq_cnt_r[i]  <= '0;
      end
      bq_head_r <= '0;
      bq_tail_r <= '0;
      bq_cnt_r  <= '0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (rq_push && rq_push_lv == 2'(i)) begin
          rq_tail_r[i] <= inc(rq_tail_r[i]);
        end
        if (rq_pop && lvl_r == 2'(i)) begin
          rq_head_r[i] <= inc(rq_head_r[i]);
        end
        rq_cnt_r[i] <= rq_cnt_r[i] + CW'(rq_push && rq_push_lv == 2'(i))
                       - CW'(rq_pop && lvl_r == 2'(i));
      end
      if (bq_push) bq_tail_r <= inc(bq_tail_r);
      if (bq_pop) bq_head_r <= inc(bq_head_r);
      bq_cnt_r <= bq_cnt_r + CW'(bq_push) - CW'(bq_pop);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      busy_r     <= '0;
      fl_valid_r <= 1'b0;
      fl_level_r <= 2'd0;
      fl_slot_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (fr_valid) begin
            it_r    <= fr_item;
            st_r    <= mlfq_pkg::ST_OK;
            slot_r  <= '0;
            level_r <= 2'd0;
            quant_r <= '0;
            wk_r    <= '0;
            scan_r  <= '0;
            left_r  <= bq_cnt_r;
            lvl_r   <= pick_lv;
            unique case (fr_item.op)
              mlfq_pkg::OP_ADMIT: state_r <= S_SCAN;
              mlfq_pkg::OP_WAKE: begin
                state_r <= (bq_cnt_r == '0) ? S_RES : S_WK_POP;
              end
              mlfq_pkg::OP_DISPATCH: begin
                if (fl_valid_r) begin
                  st_r    <= mlfq_pkg::ST_BUSY;
                  state_r <= S_RES;
                end else if (!pick_ok) begin
                  st_r    <= mlfq_pkg::ST_NONE;
                  state_r <= S_RES;
                end else begin
                  state_r <= S_DSP;
                end
              end
              mlfq_pkg::OP_REPORT: begin
                state_r <= S_RES;
                if (!fl_valid_r) begin
                  st_r <= mlfq_pkg::ST_BUSY;
                end else begin
                  slot_r     <= fl_slot_r;
                  level_r    <= fl_level_r;
                  fl_valid_r <= 1'b0;
                  if (fr_item.outcome == mlfq_pkg::OC_FINISHED) begin
                    busy_r[fl_slot_r] <= 1'b0;
                  end
                end
              end
              default: state_r <= S_RES;
            endcase
          end
        end
        S_SCAN: begin
          if (!busy_r[scan_r]) begin
            busy_r[scan_r] <= 1'b1;
            slot_r         <= scan_r;
            state_r        <= S_RES;
          end else if (scan_r == LAST) begin
            st_r    <= mlfq_pkg::ST_NO_SLOT;
            state_r <= S_RES;
          end else begin
            scan_r <= scan_r + PW'(1);
          end
        end
        S_WK_POP: state_r <= S_WK_RD;
        S_WK_RD: begin
          s_r     <= bq_rd_r;
          state_r <= S_WK_CMP;
        end
        S_WK_CMP: begin
          if (wake_hit) wk_r <= wk_r + CW'(1);
          left_r  <= left_r - CW'(1);
          state_r <= (left_r == CW'(1)) ? S_RES : S_WK_POP;
        end
        S_DSP: begin
          fl_valid_r <= 1'b1;
          fl_level_r <= lvl_r;
          fl_slot_r  <= rq_rd_r;
          slot_r     <= rq_rd_r;
          level_r    <= lvl_r;
          quant_r    <= (lvl_r[1] == 1'b0) ? base_quantum :
                        (lvl_r == 2'd2) ? (base_quantum >> 1) : (base_quantum >> 2);
          state_r    <= S_RES;
        end
        S_RES: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result fields, slot and count cut to port width
  assign slot_ext = {4'b0, slot_r};
  assign wk_ext   = {5'b0, wk_r};

  always_comb begin
    res.status      = st_r;
    res.slot        = slot_ext[3:0];
    res.level       = level_r;
    res.quantum     = quant_r;
    res.woken_count = wk_ext[4:0];
  end

endmodule

`default_nettype wire
